// File: rtl/prcs_pkg.sv
// Shared types, constants and saturation helpers for the circle reflection block.
// No dependencies; used by all modules under rtl.
`default_nettype none
package prcs_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int STEP_WIDTH  = 16;
  localparam int FRAC_BITS   = 12;
  localparam int NORM_BITS   = 16;
  localparam int OPND_WIDTH  = 26;
  localparam int PROD_WIDTH  = 2 * OPND_WIDTH;
  localparam int WIDE_WIDTH  = 54;
  localparam int ROOT_STEPS  = 24;
  localparam int DIV_STEPS   = 17;

  localparam logic [1:0] REG_WALL_RADIUS = 2'd0;
  localparam logic [1:0] REG_WALL_INSET  = 2'd1;
  localparam logic [1:0] REG_CENTRE_X    = 2'd2;
  localparam logic [1:0] REG_CENTRE_Y    = 2'd3;

  localparam logic REQ_ADVANCE = 1'b0;
  localparam logic REQ_LOAD    = 1'b1;

  typedef enum logic {
    RD_ROOT,
    RD_DIV
  } rd_mode_t;

  typedef struct packed {
    logic     start;
    rd_mode_t mode;
  } rd_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rd_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MVX, ST_MVY, ST_PY, ST_SQX, ST_SQY, ST_RAD, ST_CHK,
    ST_SX, ST_SY, ST_SUM, ST_RSTART, ST_RWAIT, ST_XSTART, ST_XWAIT,
    ST_YSTART, ST_YWAIT, ST_DX, ST_DY, ST_DOT, ST_VX, ST_VY, ST_VY2,
    ST_PX, ST_PY2, ST_PY3, ST_OUT
  } state_t;

  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
      input logic signed [WIDE_WIDTH-1:0] v);
    logic signed [WIDE_WIDTH-1:0] hi;
    logic signed [WIDE_WIDTH-1:0] lo;
    hi = WIDE_WIDTH'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    lo = -hi - WIDE_WIDTH'(1);
    if (v > hi) return hi[COORD_WIDTH-1:0];
    if (v < lo) return lo[COORD_WIDTH-1:0];
    return v[COORD_WIDTH-1:0];
  endfunction

  function automatic logic signed [COORD_WIDTH:0] sat_abs(
      input logic signed [COORD_WIDTH+1:0] v);
    logic signed [COORD_WIDTH+1:0] hi;
    logic signed [COORD_WIDTH+1:0] lo;
    hi = (COORD_WIDTH+2)'((64'sd1 <<< COORD_WIDTH) - 64'sd1);
    lo = -hi - (COORD_WIDTH+2)'(1);
    if (v > hi) return hi[COORD_WIDTH:0];
    if (v < lo) return lo[COORD_WIDTH:0];
    return v[COORD_WIDTH:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/prcs_mul.sv
// Shared signed multiplier with a registered product.
// Depends on prcs_pkg for operand and product widths.
`default_nettype none
module prcs_mul (
  input  wire logic                                    clk,
  input  wire logic signed [prcs_pkg::OPND_WIDTH-1:0]  a,
  input  wire logic signed [prcs_pkg::OPND_WIDTH-1:0]  b,
  output logic signed      [prcs_pkg::PROD_WIDTH-1:0]  prod
);
  import prcs_pkg::*;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule
`default_nettype wire

// File: rtl/prcs_rootdiv.sv
// Iterative unit: integer square root (two bits a step) or restoring division
// (one bit a step). Depends on prcs_pkg for the control and status structs.
`default_nettype none
module prcs_rootdiv (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire prcs_pkg::rd_ctl_t ctl,
  input  wire logic [47:0]       value,
  input  wire logic [23:0]       divisor,
  output prcs_pkg::rd_stat_t     stat,
  output logic [23:0]            result
);
  import prcs_pkg::*;

  rd_mode_t    mode_q;
  logic [47:0] work;
  logic [25:0] rem;
  logic [23:0] res;
  logic [4:0]  cnt;
  logic        done;
  logic [27:0] rem_sh;
  logic [27:0] trial;
  logic [27:0] diff;
  logic        ge;

  always_comb begin
    if (mode_q == RD_ROOT) begin
      rem_sh = {rem, work[47:46]};
      trial  = {2'b00, res, 2'b01};
    end else begin
      rem_sh = {1'b0, rem, work[47]};
      trial  = {4'b0000, divisor};
    end
    ge   = rem_sh >= trial;
    diff = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (ctl.start) begin
      done <= 1'b0;
      if (ctl.mode == RD_ROOT) begin
        cnt <= 5'(ROOT_STEPS);
      end else begin
        cnt <= 5'(DIV_STEPS);
      end
    end else if (cnt != '0) begin
      cnt  <= cnt - 5'd1;
      done <= cnt == 5'd1;
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mode_q <= ctl.mode;
      res    <= '0;
      if (ctl.mode == RD_ROOT) begin
        work <= value;
        rem  <= '0;
      end else begin
        // numerator sits in value[38:0]; its top bits seed the remainder
        work <= {value[16:0], 31'd0};
        rem  <= {4'd0, value[38:17]};
      end
    end else if (cnt != '0) begin
      rem <= ge ? diff[25:0] : rem_sh[25:0];
      res <= {res[22:0], ge};
      if (mode_q == RD_ROOT) begin
        work <= {work[45:0], 2'b00};
      end else begin
        work <= {work[46:0], 1'b0};
      end
    end
  end

  assign stat.busy = cnt != '0;
  assign stat.done = done;
  assign result    = res;

endmodule
`default_nettype wire

// File: rtl/particle_reflect_in_circle_step.sv
// Particle bouncing inside a circular wall.
// Input channel (in_valid / in_stall): req_type selects load or advance by
// time_step. Output channel (out_valid / out_stall): one result per item with
// the absolute position, the velocity and the bounced flag.
// Configuration: cfg_we writes cfg_data into the register at cfg_index
// (0 wall_radius, 1 wall_inset, 2 centre_x, 3 centre_y); write only when idle.
// Processing: a load goes from idle straight to the output state. An advance
// moves the position and checks it against the wall; a reflection also runs the
// shared iterative unit (24 square-root steps and up to two 17-step divisions)
// and multiplies that take turns on the one multiplier. One item is in flight
// at a time; in_stall is high until the result sits in the output register.
// A result waits in the output register while out_stall is high; the next
// item may be accepted meanwhile, and its result waits until the slot frees.
// Reset (rst, synchronous) clears position and velocity to zero and loads
// radius 200, inset 1 and centre (400, 260).
// Depends on prcs_pkg, prcs_mul and prcs_rootdiv.
`default_nettype none
module particle_reflect_in_circle_step (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        req_type,
  input  wire logic [prcs_pkg::STEP_WIDTH-1:0]         time_step,
  input  wire logic signed [prcs_pkg::COORD_WIDTH-1:0] load_pos_x,
  input  wire logic signed [prcs_pkg::COORD_WIDTH-1:0] load_pos_y,
  input  wire logic signed [prcs_pkg::COORD_WIDTH-1:0] load_vel_x,
  input  wire logic signed [prcs_pkg::COORD_WIDTH-1:0] load_vel_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [prcs_pkg::COORD_WIDTH:0]   abs_pos_x,
  output logic signed [prcs_pkg::COORD_WIDTH:0]   abs_pos_y,
  output logic signed [prcs_pkg::COORD_WIDTH-1:0] new_vel_x,
  output logic signed [prcs_pkg::COORD_WIDTH-1:0] new_vel_y,
  output logic             bounced
);
  import prcs_pkg::*;

  state_t state, state_next;

  logic [10:0] wall_radius;
  logic [10:0] wall_inset;
  logic [11:0] centre_x;
  logic [11:0] centre_y;

  logic signed [COORD_WIDTH-1:0] px, py, vx, vy;
  logic [STEP_WIDTH-1:0]         dt;
  logic signed [52:0]            acc;
  logic [22:0]                   xs, ys;
  logic [23:0]                   len;
  logic signed [17:0]            nx, ny;
  logic signed [25:0]            dot;
  logic                          hit;

  logic signed [OPND_WIDTH-1:0] mul_a, mul_b;
  logic signed [PROD_WIDTH-1:0] prod;
  rd_ctl_t     rd_ctl;
  rd_stat_t    rd_stat;
  logic [23:0] rd_result;
  logic [47:0] rd_value;

  logic [23:0]                   ax, ay;
  logic [22:0]                   rad;
  logic signed [COORD_WIDTH-1:0] land_dist;
  logic                          accept;
  logic                          slot_free;
  logic                          hit_now;
  logic signed [53:0]            acc_sum;

  assign ax   = px[23] ? 24'(-px) : 24'(px);
  assign ay   = py[23] ? 24'(-py) : 24'(py);
  assign rad  = {wall_radius, 12'd0};
  assign land_dist = $signed({1'b0, wall_radius, 12'd0}) - $signed({1'b0, wall_inset, 12'd0});
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign acc_sum   = 54'(acc) + 54'(prod);
  assign hit_now   = !((ax < {1'b0, rad}) && (ay < {1'b0, rad}) && (54'(acc) < 54'(prod)));

  prcs_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  prcs_rootdiv u_rootdiv (
    .clk     (clk),
    .rst     (rst),
    .ctl     (rd_ctl),
    .value   (rd_value),
    .divisor (len),
    .stat    (rd_stat),
    .result  (rd_result)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (req_type == REQ_LOAD) ? ST_OUT : ST_MVX;
        end
      end
      ST_MVX: state_next = ST_MVY;
      ST_MVY: state_next = ST_PY;
      ST_PY:  state_next = ST_SQX;
      ST_SQX: state_next = ST_SQY;
      ST_SQY: state_next = ST_RAD;
      ST_RAD: state_next = ST_CHK;
      ST_CHK: state_next = hit_now ? ST_SX : ST_OUT;
      ST_SX:  state_next = ST_SY;
      ST_SY:  state_next = ST_SUM;
      ST_SUM: state_next = ST_RSTART;
      ST_RSTART: state_next = ST_RWAIT;
      ST_RWAIT: begin
        if (rd_stat.done) begin
          state_next = (rd_result == '0) ? ST_DX : ST_XSTART;
        end
      end
      ST_XSTART: state_next = ST_XWAIT;
      ST_XWAIT:  state_next = rd_stat.done ? ST_YSTART : ST_XWAIT;
      ST_YSTART: state_next = ST_YWAIT;
      ST_YWAIT:  state_next = rd_stat.done ? ST_DX : ST_YWAIT;
      ST_DX:  state_next = ST_DY;
      ST_DY:  state_next = ST_DOT;
      ST_DOT: state_next = ST_VX;
      ST_VX:  state_next = ST_VY;
      ST_VY:  state_next = ST_VY2;
      ST_VY2: state_next = ST_PX;
      ST_PX:  state_next = ST_PY2;
      ST_PY2: state_next = ST_PY3;
      ST_PY3: state_next = ST_OUT;
      ST_OUT: state_next = slot_free ? ST_IDLE : ST_OUT;
      default: state_next = ST_IDLE;
    endcase
  end

  // unit controls
  always_comb begin
    mul_a       = '0;
    mul_b       = '0;
    rd_ctl      = '0;
    rd_ctl.mode = RD_ROOT;
    rd_value    = '0;
    case (state)
      ST_MVX: begin
        mul_a = 26'(vx);
        mul_b = $signed({10'd0, dt});
      end
      ST_MVY: begin
        mul_a = 26'(vy);
        mul_b = $signed({10'd0, dt});
      end
      ST_SQX: begin
        mul_a = $signed({2'b00, ax});
        mul_b = $signed({2'b00, ax});
      end
      ST_SQY: begin
        mul_a = $signed({2'b00, ay});
        mul_b = $signed({2'b00, ay});
      end
      ST_RAD: begin
        mul_a = $signed({3'b000, rad});
        mul_b = $signed({3'b000, rad});
      end
      ST_SX: begin
        mul_a = $signed({3'b000, xs});
        mul_b = $signed({3'b000, xs});
      end
      ST_SY: begin
        mul_a = $signed({3'b000, ys});
        mul_b = $signed({3'b000, ys});
      end
      ST_RSTART: begin
        rd_ctl.start = 1'b1;
        rd_value     = acc[47:0];
      end
      ST_XSTART: begin
        rd_ctl.start = 1'b1;
        rd_ctl.mode  = RD_DIV;
        rd_value     = {9'd0, xs, 16'd0};
      end
      ST_YSTART: begin
        rd_ctl.start = 1'b1;
        rd_ctl.mode  = RD_DIV;
        rd_value     = {9'd0, ys, 16'd0};
      end
      ST_DX: begin
        mul_a = 26'(vx);
        mul_b = 26'(nx);
      end
      ST_DY: begin
        mul_a = 26'(vy);
        mul_b = 26'(ny);
      end
      ST_VX: begin
        mul_a = dot;
        mul_b = 26'(nx);
      end
      ST_VY: begin
        mul_a = dot;
        mul_b = 26'(ny);
      end
      ST_PX: begin
        mul_a = 26'(nx);
        mul_b = 26'(land_dist);
      end
      ST_PY2: begin
        mul_a = 26'(ny);
        mul_b = 26'(land_dist);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wall_radius <= 11'd200;
      wall_inset  <= 11'd1;
      centre_x    <= 12'd400;
      centre_y    <= 12'd260;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WALL_RADIUS: wall_radius <= cfg_data[10:0];
        REG_WALL_INSET:  wall_inset  <= cfg_data[10:0];
        REG_CENTRE_X:    centre_x    <= cfg_data;
        REG_CENTRE_Y:    centre_y    <= cfg_data;
        default: ;
      endcase
    end
  end

  // particle state
  always_ff @(posedge clk) begin
    if (rst) begin
      px <= '0;
      py <= '0;
      vx <= '0;
      vy <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && req_type == REQ_LOAD) begin
            px <= load_pos_x;
            py <= load_pos_y;
            vx <= load_vel_x;
            vy <= load_vel_y;
          end
        end
        ST_MVY: px <= sat_coord(54'(px) + 54'(prod >>> NORM_BITS));
        ST_PY:  py <= sat_coord(54'(py) + 54'(prod >>> NORM_BITS));
        ST_VY:  vx <= sat_coord(54'(vx) - 54'(prod >>> (NORM_BITS - 1)));
        ST_VY2: vy <= sat_coord(54'(vy) - 54'(prod >>> (NORM_BITS - 1)));
        ST_PY2: px <= sat_coord(54'(prod >>> NORM_BITS));
        ST_PY3: py <= sat_coord(54'(prod >>> NORM_BITS));
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        dt  <= time_step;
        hit <= 1'b0;
      end
      ST_SQY, ST_SY, ST_DY: acc <= 53'(prod);
      ST_RAD, ST_SUM: acc <= acc_sum[52:0];
      ST_CHK: begin
        hit <= hit_now;
        // prescale so both magnitudes stay below 2^23
        if (ax[23] || ay[23]) begin
          xs <= ax[23:1];
          ys <= ay[23:1];
        end else begin
          xs <= ax[22:0];
          ys <= ay[22:0];
        end
      end
      ST_RWAIT: begin
        if (rd_stat.done) begin
          len <= rd_result;
          nx  <= 18'sd65536;
          ny  <= '0;
        end
      end
      ST_XWAIT: begin
        if (rd_stat.done) begin
          nx <= px[23] ? -$signed({1'b0, rd_result[16:0]}) : $signed({1'b0, rd_result[16:0]});
        end
      end
      ST_YWAIT: begin
        if (rd_stat.done) begin
          ny <= py[23] ? -$signed({1'b0, rd_result[16:0]}) : $signed({1'b0, rd_result[16:0]});
        end
      end
      ST_DOT: dot <= 26'(acc_sum >>> NORM_BITS);
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && slot_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && slot_free) begin
      abs_pos_x <= sat_abs(26'(px) + $signed({2'b00, centre_x, 12'd0}));
      abs_pos_y <= sat_abs(26'(py) + $signed({2'b00, centre_y, 12'd0}));
      new_vel_x <= vx;
      new_vel_y <= vy;
      bounced   <= hit;
    end
  end

  assign in_stall = state != ST_IDLE;

`ifndef ASSERT_OFF
  a_load_direct: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == REQ_LOAD) |=> state == ST_OUT)
    else $error("load did not go straight to output");

  a_unit_owned: assert property (@(posedge clk) disable iff (rst)
    rd_stat.busy |-> (state == ST_RWAIT || state == ST_XWAIT || state == ST_YWAIT))
    else $error("iterative unit busy outside a wait state");

  a_no_divide_by_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_XSTART || state == ST_YSTART) |-> len != '0)
    else $error("division started with zero length");

  a_no_bounce_on_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && !$past(in_stall)) |-> !hit)
    else $error("bounce flagged for a load");
`endif

endmodule
`default_nettype wire
